@@ src/pfrs_pkg.sv @@
// ----------------------------------------------------------------------------
// pfrs_pkg
// Shared types and constants of the page frame replacement selector.
// ----------------------------------------------------------------------------
package pfrs_pkg;

   localparam int NUM_FRAMES = 4096;
   localparam int FRAME_BITS = $clog2(NUM_FRAMES);
   localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);
   localparam int STAMP_BITS = 16;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = (STAMP_BITS > COUNT_BITS) ? STAMP_BITS : COUNT_BITS;

   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_VICTIM = 2'd2;
   localparam logic [1:0] OP_FREE   = 2'd3;

   localparam logic [2:0] POL_RANDOM  = 3'd0;
   localparam logic [2:0] POL_FIFO    = 3'd1;
   localparam logic [2:0] POL_LRU     = 3'd2;
   localparam logic [2:0] POL_LFU     = 3'd3;
   localparam logic [2:0] POL_MFU     = 3'd4;
   localparam logic [2:0] POL_CHANCE  = 3'd5;
   localparam logic [2:0] POL_ECHANCE = 3'd6;

   localparam logic CSR_POLICY    = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   localparam logic [2:0]  POLICY_RESET    = POL_FIFO;
   localparam logic [12:0] THRESHOLD_RESET = 13'h100;
   localparam logic [1:0]  REF_FULL        = 2'b11;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] frame_index;
      logic [15:0] now;
      logic [11:0] random_pick;
   } req_type;

   typedef struct packed {
      logic [11:0] result_frame;
      logic        found;
      logic [12:0] free_count;
      logic        swap_needed;
   } rsp_type;

   typedef struct packed {
      logic                  occ;
      logic [STAMP_BITS-1:0] load;
      logic [STAMP_BITS-1:0] used;
      logic [COUNT_BITS-1:0] cnt;
      logic [1:0]            refb;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

@@ src/pfrs_ram.sv @@
// ----------------------------------------------------------------------------
// pfrs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pfrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/page_frame_replacement_selector_top.sv @@
// ----------------------------------------------------------------------------
// page_frame_replacement_selector_top
// Frame table with allocation, release, access bookkeeping and victim choice.
// ----------------------------------------------------------------------------
// A request beat carries an opcode, a frame index, a time stamp and a random
// start frame; every request gives exactly one response beat with the frame,
// a found flag, the free count and the swap flag. Both channels use valid and
// stall. One request is in the block at a time; the next is taken as soon as
// the response is in the output register, even while that beat is stalled.
// Access and free read their entry, write it back and then load the output
// register. Allocate and the random policy scan the frame table from their
// start frame and stop at the first hit. FIFO, LRU, LFU and MFU make one
// full scan; the chance policies make two full scans. The table is a
// single-port-read RAM read one entry a cycle.
// After reset a clearing pass zeroes every table entry while requests are
// stalled; the CSR port is to be written by the user only while no request
// is in the block, and the block itself does not enforce this. A stalled
// response holds its beat.
// ----------------------------------------------------------------------------
module page_frame_replacement_selector_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfrs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfrs_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [12:0]       csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RMW, ST_SCAN, ST_VWRITE, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_ALLOC, PH_RAND, PH_EXT, PH_CHA, PH_CHB, PH_CHC
   } phase_type;

   localparam int FB = pfrs_pkg::FRAME_BITS;
   localparam int CB = pfrs_pkg::CNT_BITS;
   localparam int SB = pfrs_pkg::STAMP_BITS;
   localparam int KB = pfrs_pkg::KEY_BITS;

   state_type           state_ff,     state_in;
   phase_type           phase_ff,     phase_in;
   logic [2:0]          policy_ff,    policy_in;
   logic [12:0]         thr_ff,       thr_in;
   logic [CB-1:0]       free_ff,      free_in;
   pfrs_pkg::req_type   req_ff,       req_in;
   logic [CB-1:0]       scan_cnt_ff,  scan_cnt_in;
   logic [FB-1:0]       start_ff,     start_in;
   logic                pend_ff,      pend_in;
   logic [FB-1:0]       pend_idx_ff,  pend_idx_in;
   logic                pend_last_ff, pend_last_in;
   logic                best_v_ff,    best_v_in;
   logic [FB-1:0]       best_idx_ff,  best_idx_in;
   pfrs_pkg::entry_type best_ff,      best_in;
   logic                hit_v_ff,     hit_v_in;
   logic [FB-1:0]       hit_idx_ff,   hit_idx_in;
   pfrs_pkg::entry_type hit_ff,       hit_in;
   logic [11:0]         res_frame_ff, res_frame_in;
   logic                res_found_ff, res_found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pfrs_pkg::rsp_type   rsp_ff,       rsp_in;
   logic [FB-1:0]       clr_cnt_ff,   clr_cnt_in;

   logic                wr_en;
   logic [FB-1:0]       wr_addr;
   pfrs_pkg::entry_type wr_data;
   logic                rd_en;
   logic [FB-1:0]       rd_addr;
   pfrs_pkg::entry_type rd_data;

   pfrs_ram #(
      .WIDTH (pfrs_pkg::ENTRY_BITS),
      .DEPTH (pfrs_pkg::NUM_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   function automatic logic [KB-1:0] key_of(pfrs_pkg::entry_type e, logic [2:0] pol);
      logic [KB-1:0] k;
      case (pol)
         pfrs_pkg::POL_LRU: k = KB'(e.used);
         pfrs_pkg::POL_LFU: k = KB'(e.cnt);
         pfrs_pkg::POL_MFU: k = KB'(e.cnt);
         default:           k = KB'(e.load);
      endcase
      return k;
   endfunction

   function automatic pfrs_pkg::entry_type spare(pfrs_pkg::entry_type e,
                                                 logic [SB-1:0] now, logic enh);
      pfrs_pkg::entry_type r;
      r      = e;
      r.refb = enh ? (e.refb - 2'd1) : 2'd0;
      r.load = now;
      return r;
   endfunction

   logic                accept;
   logic                rsp_free;
   logic [SB-1:0]       now;
   logic                enh;
   logic [CB:0]         addr_sum;
   logic [FB-1:0]       scan_addr;
   logic                in_range;
   logic [KB-1:0]       e_key;
   logic [KB-1:0]       b_key;
   logic                better;
   pfrs_pkg::entry_type e;
   pfrs_pkg::entry_type sp;
   pfrs_pkg::entry_type upd;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign now      = req_ff.now[SB-1:0];
   assign enh      = (policy_ff == pfrs_pkg::POL_ECHANCE);
   assign addr_sum = (CB+1)'(start_ff) + (CB+1)'(scan_cnt_ff);
   assign scan_addr = (addr_sum >= (CB+1)'(pfrs_pkg::NUM_FRAMES))
                      ? FB'(addr_sum - (CB+1)'(pfrs_pkg::NUM_FRAMES)) : FB'(addr_sum);
   assign in_range = ({1'b0, req_ff.frame_index} < 13'(pfrs_pkg::NUM_FRAMES));
   assign e        = rd_data;
   assign e_key    = key_of(rd_data, policy_ff);
   assign b_key    = key_of(best_ff, policy_ff);
   assign better   = !best_v_ff || ((policy_ff == pfrs_pkg::POL_MFU) ? (e_key > b_key)
                                                                      : (e_key < b_key));
   assign sp       = spare(rd_data, now, enh);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      policy_in    = policy_ff;
      thr_in       = thr_ff;
      free_in      = free_ff;
      req_in       = req_ff;
      scan_cnt_in  = scan_cnt_ff;
      start_in     = start_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      best_v_in    = best_v_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      hit_v_in     = hit_v_ff;
      hit_idx_in   = hit_idx_ff;
      hit_in       = hit_ff;
      res_frame_in = res_frame_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      clr_cnt_in   = clr_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = scan_addr;
      upd          = rd_data;

      if (csr_we) begin
         case (csr_index)
            pfrs_pkg::CSR_POLICY:    policy_in = csr_wdata[2:0];
            pfrs_pkg::CSR_THRESHOLD: thr_in    = csr_wdata;
            default:                 thr_in    = thr_ff;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + FB'(1);
            if (clr_cnt_ff == FB'(pfrs_pkg::NUM_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_payload;
               res_frame_in = req_payload.frame_index;
               res_found_in = 1'b0;
               scan_cnt_in  = '0;
               start_in     = '0;
               best_v_in    = 1'b0;
               hit_v_in     = 1'b0;
               case (req_payload.opcode)
                  pfrs_pkg::OP_ALLOC: begin
                     state_in = ST_SCAN;
                     phase_in = PH_ALLOC;
                  end
                  pfrs_pkg::OP_VICTIM: begin
                     state_in = ST_SCAN;
                     case (policy_ff)
                        pfrs_pkg::POL_RANDOM: begin
                           phase_in = PH_RAND;
                           start_in = FB'(req_payload.random_pick % pfrs_pkg::NUM_FRAMES);
                        end
                        pfrs_pkg::POL_CHANCE:  phase_in = PH_CHA;
                        pfrs_pkg::POL_ECHANCE: phase_in = PH_CHA;
                        default:               phase_in = PH_EXT;
                     endcase
                  end
                  default: begin
                     state_in = ST_RMW;
                     rd_en    = 1'b1;
                     rd_addr  = FB'(req_payload.frame_index);
                  end
               endcase
            end
         end
         ST_RMW: begin
            wr_addr = FB'(req_ff.frame_index);
            if (in_range && e.occ) begin
               wr_en = 1'b1;
               if (req_ff.opcode == pfrs_pkg::OP_ACCESS) begin
                  upd.used = now;
                  upd.cnt  = (e.cnt == '1) ? e.cnt : e.cnt + 1'b1;
                  upd.refb = pfrs_pkg::REF_FULL;
               end else begin
                  upd.occ = 1'b0;
                  free_in = free_ff + CB'(1);
               end
            end
            wr_data  = upd;
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (scan_cnt_ff < CB'(pfrs_pkg::NUM_FRAMES)) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_idx_in  = scan_addr;
               pend_last_in = (scan_cnt_ff == CB'(pfrs_pkg::NUM_FRAMES - 1));
               scan_cnt_in  = scan_cnt_ff + CB'(1);
            end
            if (pend_ff) begin
               case (phase_ff)
                  PH_ALLOC: begin
                     if (!e.occ) begin
                        wr_en        = 1'b1;
                        upd.occ      = 1'b1;
                        upd.load     = now;
                        upd.used     = now;
                        upd.cnt      = '0;
                        upd.refb     = '0;
                        wr_data      = upd;
                        free_in      = (free_ff != '0) ? free_ff - CB'(1) : free_ff;
                        res_frame_in = 12'(pend_idx_ff);
                        res_found_in = 1'b1;
                        state_in     = ST_DONE;
                     end else if (pend_last_ff) begin
                        state_in = ST_DONE;
                     end
                  end
                  PH_RAND: begin
                     if (e.occ) begin
                        wr_en        = 1'b1;
                        upd.occ      = 1'b0;
                        wr_data      = upd;
                        free_in      = free_ff + CB'(1);
                        res_frame_in = 12'(pend_idx_ff);
                        res_found_in = 1'b1;
                        state_in     = ST_DONE;
                     end else if (pend_last_ff) begin
                        state_in = ST_DONE;
                     end
                  end
                  PH_EXT: begin
                     if (e.occ && better) begin
                        best_v_in   = 1'b1;
                        best_idx_in = pend_idx_ff;
                        best_in     = e;
                     end
                     if (pend_last_ff) begin
                        state_in = ST_VWRITE;
                     end
                  end
                  PH_CHA: begin
                     if (e.occ && (e.load < now) && (e.refb == '0)
                         && (!best_v_ff || (e.load < best_ff.load))) begin
                        best_v_in   = 1'b1;
                        best_idx_in = pend_idx_ff;
                        best_in     = e;
                     end
                     if (pend_last_ff) begin
                        scan_cnt_in = '0;
                        pend_in     = 1'b0;
                        phase_in    = best_v_in ? PH_CHB : PH_CHC;
                        best_v_in   = best_v_in;
                     end
                  end
                  PH_CHB: begin
                     if (e.occ && (pend_idx_ff != best_idx_ff)
                         && ((e.load < best_ff.load)
                             || ((e.load == best_ff.load) && (pend_idx_ff < best_idx_ff)))) begin
                        wr_en   = 1'b1;
                        wr_data = sp;
                     end
                     if (pend_last_ff) begin
                        state_in = ST_VWRITE;
                     end
                  end
                  PH_CHC: begin
                     upd = e;
                     if (e.occ && (e.load < now)) begin
                        wr_en   = 1'b1;
                        wr_data = sp;
                        upd     = sp;
                     end
                     if (!hit_v_ff && e.occ && (e.load <= now)) begin
                        hit_v_in    = 1'b1;
                        hit_idx_in  = pend_idx_ff;
                        hit_in      = upd;
                        hit_in.refb = '0;
                     end
                     if (e.occ && (!best_v_ff || (e.load < best_ff.load))) begin
                        best_v_in   = 1'b1;
                        best_idx_in = pend_idx_ff;
                        best_in     = e;
                     end
                     if (pend_last_ff) begin
                        state_in = ST_VWRITE;
                        if (hit_v_in) begin
                           best_v_in   = 1'b1;
                           best_idx_in = hit_idx_in;
                           best_in     = hit_in;
                        end else if (best_v_in && (best_in.refb != '0)) begin
                           best_in.refb = '0;
                           best_in.load = now;
                        end
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
            if (state_in != ST_SCAN) begin
               pend_in = 1'b0;
            end
         end
         ST_VWRITE: begin
            if (best_v_ff) begin
               wr_en        = 1'b1;
               wr_addr      = best_idx_ff;
               upd          = best_ff;
               upd.occ      = 1'b0;
               wr_data      = upd;
               free_in      = free_ff + CB'(1);
               res_frame_in = 12'(best_idx_ff);
               res_found_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_frame = res_frame_ff;
               rsp_in.found        = res_found_ff;
               rsp_in.free_count   = 13'(free_ff);
               rsp_in.swap_needed  = (13'(free_ff) < thr_ff);
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_ALLOC;
         policy_ff    <= pfrs_pkg::POLICY_RESET;
         thr_ff       <= pfrs_pkg::THRESHOLD_RESET;
         free_ff      <= CB'(pfrs_pkg::NUM_FRAMES);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         policy_ff    <= policy_in;
         thr_ff       <= thr_in;
         free_ff      <= free_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
      req_ff       <= req_in;
      scan_cnt_ff  <= scan_cnt_in;
      start_ff     <= start_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      best_v_ff    <= best_v_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      hit_v_ff     <= hit_v_in;
      hit_idx_ff   <= hit_idx_in;
      hit_ff       <= hit_in;
      res_frame_ff <= res_frame_in;
      res_found_ff <= res_found_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= CB'(pfrs_pkg::NUM_FRAMES))
      else $error("free frame count exceeds table size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while another is in progress");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("table entry read and written in the same cycle");

   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("response beat not loaded on completion");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page frame replacement selector. A directed
// table and random traffic under every policy are run against a predictor of
// the frame table; each response beat is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int LONG_HOLD      = 400;
   localparam int NF             = pfrs_pkg::NUM_FRAMES;

   typedef struct {
      pfrs_pkg::req_type rq;
      bit                chk;
      pfrs_pkg::rsp_type ex;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   pfrs_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   pfrs_pkg::rsp_type rsp_payload;
   logic    csr_we = 1'b0;
   logic    csr_index = pfrs_pkg::CSR_POLICY;
   logic [12:0] csr_wdata = '0;

   bit              frame_occ [NF];
   logic [15:0]     frame_load [NF];
   logic [15:0]     frame_used [NF];
   logic [15:0]     frame_cnt [NF];
   logic [1:0]      frame_ref [NF];
   int unsigned     free_total;
   logic [2:0]      cur_policy;
   logic [12:0]     cur_threshold;

   pfrs_pkg::rsp_type expected_rsp_q[$];
   row_type directed[$];
   int      errors = 0;
   int      beats_checked = 0;
   int      idle_cycles = 0;
   bit      long_hold = 1'b0;
   bit      quiet_rsp = 1'b0;
   bit      quiet_req = 1'b0;
   logic [15:0] clock_stamp = '0;

   page_frame_replacement_selector_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void table_reset();
      for (int i = 0; i < NF; i++) begin
         frame_occ[i] = 0; frame_load[i] = '0; frame_used[i] = '0;
         frame_cnt[i] = '0; frame_ref[i] = '0;
      end
      free_total = NF;
      cur_policy = pfrs_pkg::POLICY_RESET;
      cur_threshold = pfrs_pkg::THRESHOLD_RESET;
   endfunction

   // Key 0 is the load stamp, 1 the use stamp, 2 the use count.
   function automatic int find_extreme(int key, bit largest);
      int best;
      logic [15:0] k, kb;
      best = -1;
      for (int i = 0; i < NF; i++) begin
         if (frame_occ[i]) begin
            k = (key == 0) ? frame_load[i] : (key == 1) ? frame_used[i] : frame_cnt[i];
            if (best >= 0)
               kb = (key == 0) ? frame_load[best] :
                    (key == 1) ? frame_used[best] : frame_cnt[best];
            if (best < 0 || (largest ? k > kb : k < kb)) best = i;
         end
      end
      return best;
   endfunction

   function automatic void spare_frame(int i, logic [15:0] stamp, bit enhanced);
      frame_ref[i] = enhanced ? frame_ref[i] - 2'd1 : 2'd0;
      frame_load[i] = stamp;
   endfunction

   function automatic int find_chance(logic [15:0] stamp, bit enhanced);
      int v, h;
      logic [15:0] vs;
      v = -1; h = -1;
      for (int i = 0; i < NF; i++)
         if (frame_occ[i] && frame_load[i] < stamp && frame_ref[i] == 2'd0 &&
             (v < 0 || frame_load[i] < frame_load[v])) v = i;
      if (v >= 0) begin
         vs = frame_load[v];
         for (int i = 0; i < NF; i++)
            if (frame_occ[i] && i != v &&
                (frame_load[i] < vs || (frame_load[i] == vs && i < v)))
               spare_frame(i, stamp, enhanced);
         return v;
      end
      for (int i = 0; i < NF; i++)
         if (frame_occ[i] && frame_load[i] < stamp) spare_frame(i, stamp, enhanced);
      for (int i = 0; i < NF; i++)
         if (frame_occ[i] && frame_load[i] == stamp) begin
            h = i;
            break;
         end
      if (h >= 0) begin
         frame_ref[h] = 2'd0;
         return h;
      end
      h = find_extreme(0, 1'b0);
      if (h >= 0 && frame_ref[h] != 2'd0) begin
         frame_ref[h] = 2'd0;
         frame_load[h] = stamp;
      end
      return h;
   endfunction

   function automatic pfrs_pkg::rsp_type frame_table_step(pfrs_pkg::req_type r);
      pfrs_pkg::rsp_type o;
      int v, f;
      v = -1;
      o.result_frame = r.frame_index;
      o.found = 1'b0;
      case (r.opcode)
         pfrs_pkg::OP_ACCESS: begin
            if (frame_occ[r.frame_index]) begin
               frame_used[r.frame_index] = r.now;
               if (frame_cnt[r.frame_index] != 16'hFFFF)
                  frame_cnt[r.frame_index] = frame_cnt[r.frame_index] + 16'd1;
               frame_ref[r.frame_index] = pfrs_pkg::REF_FULL;
            end
         end
         pfrs_pkg::OP_ALLOC: begin
            for (int i = 0; i < NF; i++)
               if (!frame_occ[i]) begin
                  frame_occ[i] = 1; frame_load[i] = r.now; frame_used[i] = r.now;
                  frame_cnt[i] = '0; frame_ref[i] = '0;
                  if (free_total > 0) free_total--;
                  o.result_frame = i[11:0];
                  o.found = 1'b1;
                  break;
               end
         end
         pfrs_pkg::OP_VICTIM: begin
            case (cur_policy)
               pfrs_pkg::POL_RANDOM: begin
                  for (int i = 0; i < NF; i++) begin
                     f = (r.random_pick + i) % NF;
                     if (frame_occ[f]) begin
                        v = f;
                        break;
                     end
                  end
               end
               pfrs_pkg::POL_LRU:     v = find_extreme(1, 1'b0);
               pfrs_pkg::POL_LFU:     v = find_extreme(2, 1'b0);
               pfrs_pkg::POL_MFU:     v = find_extreme(2, 1'b1);
               pfrs_pkg::POL_CHANCE:  v = find_chance(r.now, 1'b0);
               pfrs_pkg::POL_ECHANCE: v = find_chance(r.now, 1'b1);
               default:               v = find_extreme(0, 1'b0);
            endcase
            if (v >= 0) begin
               frame_occ[v] = 0;
               free_total++;
               o.result_frame = v[11:0];
               o.found = 1'b1;
            end
         end
         default: begin
            if (frame_occ[r.frame_index]) begin
               frame_occ[r.frame_index] = 0;
               free_total++;
            end
         end
      endcase
      o.free_count = free_total[12:0];
      o.swap_needed = (free_total < cur_threshold);
      return o;
   endfunction

   function automatic row_type make_row(logic [1:0] op, logic [11:0] idx,
                                        logic [15:0] stamp, logic [11:0] pick,
                                        bit chk, logic [11:0] fr, logic fd,
                                        logic [12:0] fc, logic sw);
      row_type w;
      w.rq = '{opcode: op, frame_index: idx, now: stamp, random_pick: pick};
      w.chk = chk;
      w.ex = '{result_frame: fr, found: fd, free_count: fc, swap_needed: sw};
      return w;
   endfunction

   function automatic pfrs_pkg::req_type random_req();
      pfrs_pkg::req_type r;
      int sel;
      sel = $urandom_range(0, 99);
      r.opcode = (sel < 32) ? pfrs_pkg::OP_ALLOC : (sel < 62) ? pfrs_pkg::OP_ACCESS :
                 (sel < 82) ? pfrs_pkg::OP_VICTIM : pfrs_pkg::OP_FREE;
      r.frame_index = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
      clock_stamp = clock_stamp + 16'($urandom_range(0, 3));
      r.now = ($urandom_range(0, 9) == 0) ? 16'($urandom) : clock_stamp;
      r.random_pick = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   task automatic csr_write(logic idx, logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == pfrs_pkg::CSR_POLICY) cur_policy = value[2:0];
      else cur_threshold = value;
      @(negedge clock);
   endtask

   // Entered and left at a falling edge.
   task automatic send_beat(pfrs_pkg::req_type r, bit chk, pfrs_pkg::rsp_type ex);
      int gap;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(chk ? ex : frame_table_step(r));
      if (chk) void'(frame_table_step(r));
      @(negedge clock);
      gap = quiet_req ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      pfrs_pkg::rsp_type none;
      logic [12:0] thresholds [8] = '{13'd0, 13'd4096, 13'd4095, 13'd4090,
                                      13'd1, 13'd4094, 13'd256, 13'd4093};
      none = '0;
      table_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed.push_back(make_row(pfrs_pkg::OP_VICTIM, 12'd5, 16'd0, 12'hFFF,
                                  1, 12'd5, 0, 13'd4096, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ACCESS, 12'd7, 16'd9, 12'd0,
                                  1, 12'd7, 0, 13'd4096, 0));
      directed.push_back(make_row(pfrs_pkg::OP_FREE, 12'hFFF, 16'd0, 12'd0,
                                  1, 12'hFFF, 0, 13'd4096, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ALLOC, 12'd0, 16'd5, 12'd0,
                                  1, 12'd0, 1, 13'd4095, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ALLOC, 12'd0, 16'd3, 12'd0,
                                  1, 12'd1, 1, 13'd4094, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ALLOC, 12'hFFF, 16'hFFFF, 12'd0,
                                  1, 12'd2, 1, 13'd4093, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ACCESS, 12'd0, 16'hFFFF, 12'd0,
                                  1, 12'd0, 0, 13'd4093, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ACCESS, 12'd2, 16'd0, 12'd0,
                                  1, 12'd2, 0, 13'd4093, 0));
      directed.push_back(make_row(pfrs_pkg::OP_VICTIM, 12'd0, 16'd10, 12'd0,
                                  1, 12'd1, 1, 13'd4094, 0));
      directed.push_back(make_row(pfrs_pkg::OP_FREE, 12'd0, 16'd0, 12'd0,
                                  1, 12'd0, 0, 13'd4095, 0));
      directed.push_back(make_row(pfrs_pkg::OP_FREE, 12'd0, 16'd0, 12'd0,
                                  1, 12'd0, 0, 13'd4095, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ALLOC, 12'hFFF, 16'd0, 12'hFFF,
                                  1, 12'd0, 1, 13'd4094, 0));
      directed.push_back(make_row(pfrs_pkg::OP_ACCESS, 12'd0, 16'd20, 12'd0,
                                  0, 0, 0, 0, 0));
      directed.push_back(make_row(pfrs_pkg::OP_VICTIM, 12'd0, 16'd30, 12'd0,
                                  0, 0, 0, 0, 0));
      directed.push_back(make_row(pfrs_pkg::OP_VICTIM, 12'd0, 16'd31, 12'd0,
                                  0, 0, 0, 0, 0));
      directed.push_back(make_row(pfrs_pkg::OP_VICTIM, 12'hABC, 16'd32, 12'd0,
                                  1, 12'hABC, 0, 13'd4096, 0));
      foreach (directed[i]) send_beat(directed[i].rq, directed[i].chk, directed[i].ex);
      drain();

      for (int p = 0; p < 8; p++) begin
         csr_write(pfrs_pkg::CSR_POLICY, 13'(p));
         csr_write(pfrs_pkg::CSR_THRESHOLD,
                   (p == 7) ? 13'($urandom_range(0, 4096)) : thresholds[p]);
         quiet_rsp = (p == 2);
         quiet_req = (p == 2) || (p == 3);
         if (p == 3) long_hold = 1'b1;
         for (int n = 0; n < 16; n++) send_beat(random_req(), 0, none);
         long_hold = 1'b0;
         drain();
      end

      $display("Covered every opcode under all eight policy codes, %0d beats checked,",
               beats_checked);
      $display("threshold extremes, empty-table victims and back-pressure on both sides.");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      int n;
      forever begin
         @(negedge clock);
         n = long_hold ? LONG_HOLD : quiet_rsp ? 0 : $urandom_range(0, 16);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      pfrs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (expected_rsp_q.size() == 0) begin
            report("response beats outstanding", 1, 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_payload.result_frame !== want.result_frame)
               report("result_frame", rsp_payload.result_frame, want.result_frame);
            if (rsp_payload.found !== want.found)
               report("found", rsp_payload.found, want.found);
            if (rsp_payload.free_count !== want.free_count)
               report("free_count", rsp_payload.free_count, want.free_count);
            if (rsp_payload.swap_needed !== want.swap_needed)
               report("swap_needed", rsp_payload.swap_needed, want.swap_needed);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
